@@ hdl/rwagc_pkg.sv @@
package rwagc_pkg;

  localparam int unsigned MaxWindow  = 4096;
  localparam int unsigned AddrW      = $clog2(MaxWindow);
  localparam int unsigned WinW       = AddrW + 1;
  localparam int unsigned SqW        = 30;
  localparam int unsigned SumW       = 42;
  localparam int unsigned PosW       = 6;
  localparam int unsigned FracW      = 16;
  localparam int unsigned LogW       = PosW + FracW;
  localparam int unsigned MantW      = 31;
  localparam int unsigned LogIters   = 16;
  localparam int unsigned ExpSteps   = 10;
  localparam int unsigned IterW      = 4;
  localparam int unsigned PaddrW     = 5;

  localparam logic [15:0]        OutLimit   = 16'd31130;
  localparam logic signed [15:0] LevelFloor = -16'sd25600;
  localparam logic signed [23:0] LogBias    = 24'sd1966080;
  localparam logic [17:0]        DbPerOct   = 18'd197283;

  localparam logic [MantW-1:0] Exp2Tab [ExpSteps] = '{
    31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436, 31'd1097253708,
    31'd1085434106, 31'd1079572136, 31'd1076653033, 31'd1075196444, 31'd1074468888
  };

  typedef enum logic [2:0] {
    REG_TARGET  = 3'd0,
    REG_ATTACK  = 3'd1,
    REG_RELEASE = 3'd2,
    REG_MAXG    = 3'd3,
    REG_MING    = 3'd4,
    REG_NOISE   = 3'd5,
    REG_WINDOW  = 3'd6,
    REG_NONE    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [14:0] target_level;
    logic [15:0]        attack_coef;
    logic [15:0]        release_coef;
    logic [12:0]        max_gain;
    logic signed [14:0] min_gain;
    logic signed [15:0] noise_threshold;
    logic [12:0]        window_length;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_INIT, ST_CLEAR, ST_WLOAD, ST_WNORM, ST_WSQ, ST_WSTORE, ST_IDLE, ST_READ,
    ST_SLOAD, ST_SNORM, ST_SSQ, ST_LVL1, ST_LVL2, ST_STEP, ST_GAIN, ST_TMUL,
    ST_EXPI, ST_EXP, ST_APPLY, ST_ROUND
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_INIT, OP_CLEAR, OP_LOADW, OP_NORM, OP_SQ, OP_STOREW, OP_ACCEPT,
    OP_UPDATE, OP_LOADS, OP_LVL1, OP_LVL2, OP_STEP, OP_GAIN, OP_TMUL, OP_EXPI,
    OP_EXP, OP_APPLY, OP_ROUND
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IterW-1:0] iter;
  } cmd_t;

  typedef struct packed {
    logic norm_done;
    logic sum_zero;
    logic clr_last;
    logic out_free;
  } status_t;

endpackage

@@ hdl/rwagc_if.sv @@
interface rwagc_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface rwagc_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;
  logic signed [15:0] level_db;
  logic signed [14:0] gain_db;
  logic               gate_closed;
  modport source (output valid, output sample_out, output level_db, output gain_db,
                  output gate_closed, input ready);
  modport sink (input valid, input sample_out, input level_db, input gain_db,
                input gate_closed, output ready);
endinterface

@@ hdl/rwagc_ram.sv @@
module rwagc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ hdl/rwagc_regs.sv @@
module rwagc_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rwagc_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output rwagc_pkg::cfg_t            cfg_o,
  output logic                       win_wr_o
);
  import rwagc_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx   = reg_idx_e'(paddr[4:2]);
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_TARGET:  cfg_d.target_level    = pwdata[14:0];
        REG_ATTACK:  cfg_d.attack_coef     = pwdata[15:0];
        REG_RELEASE: cfg_d.release_coef    = pwdata[15:0];
        REG_MAXG:    cfg_d.max_gain        = pwdata[12:0];
        REG_MING:    cfg_d.min_gain        = pwdata[14:0];
        REG_NOISE:   cfg_d.noise_threshold = pwdata[15:0];
        REG_WINDOW:  cfg_d.window_length   = pwdata[12:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_level    <= 15'sd0;
      cfg_q.attack_coef     <= 16'hFFFF;
      cfg_q.release_coef    <= 16'hFFFF;
      cfg_q.max_gain        <= 13'd7680;
      cfg_q.min_gain        <= -15'sd10240;
      cfg_q.noise_threshold <= -16'sd15360;
      cfg_q.window_length   <= 13'd4096;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      REG_TARGET:  prdata = {17'd0, cfg_q.target_level};
      REG_ATTACK:  prdata = {16'd0, cfg_q.attack_coef};
      REG_RELEASE: prdata = {16'd0, cfg_q.release_coef};
      REG_MAXG:    prdata = {19'd0, cfg_q.max_gain};
      REG_MING:    prdata = {17'd0, cfg_q.min_gain};
      REG_NOISE:   prdata = {16'd0, cfg_q.noise_threshold};
      REG_WINDOW:  prdata = {19'd0, cfg_q.window_length};
      default:     prdata = 32'd0;
    endcase
  end

  assign pready   = 1'b1;
  assign cfg_o    = cfg_q;
  assign win_wr_o = wr_en && (idx == REG_WINDOW);
endmodule

@@ hdl/rwagc_ctrl.sv @@
module rwagc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                win_wr_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rwagc_pkg::status_t  status_i,
  output rwagc_pkg::cmd_t     cmd_o
);
  import rwagc_pkg::*;

  state_e           state_q, state_d;
  logic [IterW-1:0] iter_q, iter_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT:   state_d = ST_CLEAR;
      ST_CLEAR:  if (status_i.clr_last) state_d = ST_WLOAD;
      ST_WLOAD:  state_d = ST_WNORM;
      ST_WNORM:  if (status_i.norm_done) state_d = ST_WSQ;
      ST_WSQ:    if (iter_q == IterW'(LogIters - 1)) state_d = ST_WSTORE;
      ST_WSTORE: state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = ST_READ;
      ST_READ:   state_d = ST_SLOAD;
      ST_SLOAD:  state_d = status_i.sum_zero ? ST_LVL1 : ST_SNORM;
      ST_SNORM:  if (status_i.norm_done) state_d = ST_SSQ;
      ST_SSQ:    if (iter_q == IterW'(LogIters - 1)) state_d = ST_LVL1;
      ST_LVL1:   state_d = ST_LVL2;
      ST_LVL2:   state_d = ST_STEP;
      ST_STEP:   state_d = ST_GAIN;
      ST_GAIN:   state_d = ST_TMUL;
      ST_TMUL:   state_d = ST_EXPI;
      ST_EXPI:   state_d = ST_EXP;
      ST_EXP:    if (iter_q == IterW'(ExpSteps - 1)) state_d = ST_APPLY;
      ST_APPLY:  state_d = ST_ROUND;
      ST_ROUND:  if (status_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_INIT;
    endcase
    if (win_wr_i) begin
      state_d = ST_INIT;
    end
    iter_d = (state_d != state_q) ? '0 : iter_q + 1'b1;
  end

  always_comb begin
    cmd_o.iter = iter_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT:   cmd_o.op = OP_INIT;
      ST_CLEAR:  cmd_o.op = OP_CLEAR;
      ST_WLOAD:  cmd_o.op = OP_LOADW;
      ST_WNORM:  cmd_o.op = OP_NORM;
      ST_WSQ:    cmd_o.op = OP_SQ;
      ST_WSTORE: cmd_o.op = OP_STOREW;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.op   = in_valid_i ? OP_ACCEPT : OP_NONE;
      end
      ST_READ:   cmd_o.op = OP_UPDATE;
      ST_SLOAD:  cmd_o.op = OP_LOADS;
      ST_SNORM:  cmd_o.op = OP_NORM;
      ST_SSQ:    cmd_o.op = OP_SQ;
      ST_LVL1:   cmd_o.op = OP_LVL1;
      ST_LVL2:   cmd_o.op = OP_LVL2;
      ST_STEP:   cmd_o.op = OP_STEP;
      ST_GAIN:   cmd_o.op = OP_GAIN;
      ST_TMUL:   cmd_o.op = OP_TMUL;
      ST_EXPI:   cmd_o.op = OP_EXPI;
      ST_EXP:    cmd_o.op = OP_EXP;
      ST_APPLY:  cmd_o.op = OP_APPLY;
      ST_ROUND:  cmd_o.op = status_i.out_free ? OP_ROUND : OP_NONE;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end
endmodule

@@ hdl/rwagc_dp.sv @@
module rwagc_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rwagc_pkg::cfg_t    cfg_i,
  input  rwagc_pkg::cmd_t    cmd_i,
  output rwagc_pkg::status_t status_o,
  input  logic signed [15:0] sample_in_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic signed [15:0] sample_out_o,
  output logic signed [15:0] level_db_o,
  output logic signed [14:0] gain_db_o,
  output logic               gate_closed_o
);
  import rwagc_pkg::*;

  logic [AddrW-1:0]   clr_addr_q, ptr_q;
  logic [SumW-1:0]    sum_q, norm_q;
  logic signed [14:0] g_q;
  logic signed [15:0] s_q, lv_q;
  logic [15:0]        a_q;
  logic [SqW-1:0]     sq_q, old_w;
  logic [PosW-1:0]    p_q;
  logic [FracW-1:0]   fr_q;
  logic [MantW-1:0]   m_q;
  logic [LogW-1:0]    lw_q;
  logic               zero_q, dpos_q, gate_q, dir_q;
  logic [40:0]        lprod_q;
  logic [31:0]        sprod_q;
  logic signed [31:0] tprod_q;
  logic [46:0]        aprod_q;
  logic signed [5:0]  n_q;
  logic [9:0]         f_q;
  logic               out_valid_q;
  logic signed [15:0] out_s_q, out_lv_q;
  logic signed [14:0] out_g_q;
  logic               out_gate_q;

  // Effective window: zero acts as one, anything above the store depth as the depth.
  logic [WinW-1:0] weff;
  always_comb begin
    if (cfg_i.window_length == '0) weff = WinW'(1);
    else if (cfg_i.window_length > WinW'(MaxWindow)) weff = WinW'(MaxWindow);
    else weff = cfg_i.window_length;
  end

  // Input square, saturated to one below full scale squared.
  logic [16:0] s_neg;
  logic [15:0] a_in;
  logic [31:0] sq_full;
  assign s_neg   = -{sample_in_i[15], sample_in_i};
  assign a_in    = sample_in_i[15] ? s_neg[15:0] : sample_in_i;
  assign sq_full = a_in * a_in;

  // Running sum and ring pointer update.
  logic [SumW:0]   sum_add;
  logic [SumW:0]   sum_sub;
  logic [WinW-1:0] ptr_inc;
  assign sum_add = {1'b0, sum_q} + {13'd0, sq_q};
  assign sum_sub = sum_add - {13'd0, old_w};
  assign ptr_inc = {1'b0, ptr_q} + 1'b1;

  // Bit-serial log2 fraction: one squaring per cycle.
  logic [MantW-1:0] msrc;
  logic [61:0]      msq;
  assign msrc = (cmd_i.iter == '0) ? norm_q[SumW-1 -: MantW] : m_q;
  assign msq  = msrc * msrc;

  // Level from the two logarithms.
  logic signed [23:0] dval;
  logic [23:0]        dneg;
  logic [41:0]        lrnd;
  logic [17:0]        lmag;
  assign dval = $signed({2'b00, p_q, fr_q}) - $signed({2'b00, lw_q}) - LogBias;
  assign dneg = -dval;
  assign lrnd = {1'b0, lprod_q} + 42'd8388608;
  assign lmag = lrnd[41:24];

  // Target gain, clamp and smoothing step.
  logic signed [16:0] tg0, tg1, tg2, maxg, ming, gext;
  logic signed [15:0] delta;
  logic [15:0]        dabs;
  logic [15:0]        coef;
  logic [32:0]        srnd;
  logic [16:0]        step;
  logic signed [16:0] g_up, g_dn;
  assign tg0  = {{2{cfg_i.target_level[14]}}, cfg_i.target_level} - {lv_q[15], lv_q};
  assign maxg = {4'd0, cfg_i.max_gain};
  assign ming = {{2{cfg_i.min_gain[14]}}, cfg_i.min_gain};
  assign tg1  = (tg0 > maxg) ? maxg : tg0;
  assign tg2  = (tg1 < ming) ? ming : tg1;
  assign gext = {{2{g_q[14]}}, g_q};
  assign delta = tg2[15:0] - {g_q[14], g_q};
  assign dabs = delta[15] ? 16'(-delta) : delta;
  assign coef = (tg2 > gext) ? cfg_i.attack_coef : cfg_i.release_coef;
  assign srnd = {1'b0, sprod_q} + 33'd65535;
  assign step = srnd[32:16];
  assign g_up = gext + $signed(step);
  assign g_dn = gext - $signed(step);

  // Exponent: products of the 2^(2^-(k+1)) root table, rounded to nearest.
  logic [IterW-1:0] fidx;
  logic [61:0]      eprod;
  logic [61:0]      ernd;
  assign fidx  = IterW'(ExpSteps - 1) - cmd_i.iter;
  assign eprod = m_q * Exp2Tab[cmd_i.iter];
  assign ernd  = eprod + 62'd536870912;

  // Final scaling with round-half-up, clamp and sign.
  logic [5:0]  sh;
  logic [47:0] arnd;
  logic [47:0] qv;
  logic [15:0] omag;
  assign sh   = 6'd30 - n_q;
  assign arnd = {1'b0, aprod_q} + (48'd1 << (sh - 6'd1));
  assign qv   = arnd >> sh;
  assign omag = (qv > {32'd0, OutLimit}) ? OutLimit : qv[15:0];

  rwagc_ram #(.Width(SqW), .Depth(MaxWindow)) u_ring (
    .clk_i   (clk_i),
    .we_i    ((cmd_i.op == OP_CLEAR) || (cmd_i.op == OP_UPDATE)),
    .waddr_i ((cmd_i.op == OP_CLEAR) ? clr_addr_q : ptr_q),
    .wdata_i ((cmd_i.op == OP_CLEAR) ? '0 : sq_q),
    .re_i    (cmd_i.op == OP_ACCEPT),
    .raddr_i (ptr_q),
    .rdata_o (old_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      ptr_q      <= '0;
      sum_q      <= '0;
      g_q        <= '0;
    end else begin
      case (cmd_i.op)
        OP_INIT: begin
          clr_addr_q <= '0;
          ptr_q      <= '0;
          sum_q      <= '0;
          g_q        <= '0;
        end
        OP_CLEAR:  clr_addr_q <= clr_addr_q + 1'b1;
        OP_UPDATE: begin
          sum_q <= (sum_add >= {13'd0, old_w}) ? sum_sub[SumW-1:0] : '0;
          ptr_q <= (ptr_inc >= weff) ? '0 : ptr_inc[AddrW-1:0];
        end
        OP_GAIN: if (!gate_q) g_q <= dir_q ? g_dn[14:0] : g_up[14:0];
        default: g_q <= g_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_ACCEPT: begin
        s_q  <= sample_in_i;
        a_q  <= a_in;
        sq_q <= (sq_full > 32'h3FFF_FFFF) ? {SqW{1'b1}} : sq_full[SqW-1:0];
      end
      OP_LOADW: begin
        norm_q <= {{(SumW - WinW){1'b0}}, weff};
        p_q    <= PosW'(SumW - 1);
        fr_q   <= '0;
      end
      OP_LOADS: begin
        norm_q <= sum_q;
        p_q    <= PosW'(SumW - 1);
        fr_q   <= '0;
        zero_q <= (sum_q == '0);
      end
      OP_NORM: begin
        if (!norm_q[SumW-1]) begin
          if (norm_q[SumW-1 -: 8] == 8'd0) begin
            norm_q <= norm_q << 8;
            p_q    <= p_q - PosW'(8);
          end else begin
            norm_q <= norm_q << 1;
            p_q    <= p_q - 1'b1;
          end
        end
      end
      OP_SQ: begin
        if (msq[61]) begin
          m_q  <= msq[61:31];
          fr_q <= {fr_q[FracW-2:0], 1'b1};
        end else begin
          m_q  <= msq[60:30];
          fr_q <= {fr_q[FracW-2:0], 1'b0};
        end
      end
      OP_STOREW: lw_q <= {p_q, fr_q};
      OP_LVL1: begin
        dpos_q  <= !dval[23];
        lprod_q <= dneg[22:0] * DbPerOct;
      end
      OP_LVL2: begin
        if (zero_q) lv_q <= LevelFloor;
        else if (dpos_q) lv_q <= '0;
        else if (lmag > 18'd25600) lv_q <= LevelFloor;
        else lv_q <= 16'(-$signed({1'b0, lmag[14:0]}));
      end
      OP_STEP: begin
        gate_q  <= (lv_q < cfg_i.noise_threshold);
        dir_q   <= delta[15];
        sprod_q <= dabs[14:0] * (17'h10000 - {1'b0, coef});
      end
      OP_TMUL: tprod_q <= $signed(g_q) * $signed(17'sd43541) + 32'sd32768;
      OP_EXPI: begin
        n_q <= tprod_q[31:26];
        f_q <= tprod_q[25:16];
        m_q <= 31'h4000_0000;
      end
      OP_EXP: if (f_q[fidx]) m_q <= ernd[60:30];
      OP_APPLY: aprod_q <= a_q * m_q;
      OP_ROUND: begin
        out_s_q    <= s_q[15] ? 16'(-omag) : omag;
        out_lv_q   <= lv_q;
        out_g_q    <= g_q;
        out_gate_q <= gate_q;
      end
      default: m_q <= m_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_ROUND) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.norm_done = norm_q[SumW-1];
  assign status_o.sum_zero  = (sum_q == '0);
  assign status_o.clr_last  = (clr_addr_q == {AddrW{1'b1}});
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign sample_out_o  = out_s_q;
  assign level_db_o    = out_lv_q;
  assign gain_db_o     = out_g_q;
  assign gate_closed_o = out_gate_q;
endmodule

@@ hdl/rms_window_agc_core.sv @@
// Channel   Direction  Payload                                        Handshake
// in_if     sink       sample_in                                      valid/ready
// out_if    source     sample_out, level_db, gain_db, gate_closed     valid/ready
// APB       slave      target_level .. window_length at 4*index       psel/penable/pready
//
// Each sample runs the whole sequence before the next one is accepted: the log2
// needs a normalising shift and sixteen squarings (both skipped when the window
// sum is zero), the exponent ten table products.
// After reset and after every window_length write a clearing pass sweeps the
// 4096-entry square ring and then derives log2 of the window; no sample is
// taken meanwhile.
// A finished result sits in the output register while the next sample is taken;
// the next result, and with it the input, waits until that register is free.
module rms_window_agc_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rwagc_sample_if.sink                   in_if,
  rwagc_result_if.source                 out_if,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rwagc_pkg::PaddrW-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import rwagc_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic    win_wr;

  rwagc_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg_o    (cfg),
    .win_wr_o (win_wr)
  );

  rwagc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .win_wr_i   (win_wr),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rwagc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .status_o      (status),
    .sample_in_i   (in_if.sample_in),
    .out_ready_i   (out_if.ready),
    .out_valid_o   (out_if.valid),
    .sample_out_o  (out_if.sample_out),
    .level_db_o    (out_if.level_db),
    .gain_db_o     (out_if.gain_db),
    .gate_closed_o (out_if.gate_closed)
  );
endmodule

@@ hdl/rwagc_chk.sv @@
module rwagc_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [rwagc_pkg::PaddrW-1:0] paddr
);
  import rwagc_pkg::*;

  // Only one sample is in work at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken twice in a row");

  // A window write starts the clearing pass.
  a_clear_on_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr[4:2] == REG_WINDOW) |=> !in_ready_i)
    else $error("input ready during clearing pass");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");
endmodule

bind rms_window_agc_core rwagc_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr)
);

@@ verif/rms_window_agc_core_test.sv @@
`timescale 1ns / 1ps

module rms_window_agc_core_test;
  import rwagc_pkg::*;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic signed [15:0] level_db;
    logic signed [14:0] gain_db;
    logic               gate_closed;
  } agc_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  rwagc_sample_if in_ch ();
  rwagc_result_if out_ch ();

  rms_window_agc_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_ch.sink), .out_if(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk_i = ~clk_i;

  // Shadow of the block's configuration and state.
  int signed   m_target, m_maxg, m_ming, m_noise, m_gain;
  int unsigned m_attack, m_release, m_window, m_ptr;
  longint unsigned m_ring [MaxWindow];
  longint unsigned m_sum;

  logic signed [15:0] pending_samples [$];
  agc_result_t        expected_results [$];
  int  mismatches = 0;
  bit  stall_free = 1'b0;
  bit  hold_off = 1'b0;
  int  hold_cycles = 0;
  bit  in_taken = 1'b0;

  function automatic void clear_shadow();
    for (int i = 0; i < MaxWindow; i++) m_ring[i] = 0;
    m_sum = 0;
    m_ptr = 0;
    m_gain = 0;
  endfunction

  function automatic void apply_register(reg_idx_e idx, logic [31:0] v);
    case (idx)
      REG_TARGET:  m_target = $signed(v[14:0]);
      REG_ATTACK:  m_attack = v[15:0];
      REG_RELEASE: m_release = v[15:0];
      REG_MAXG:    m_maxg = v[12:0];
      REG_MING:    m_ming = $signed(v[14:0]);
      REG_NOISE:   m_noise = $signed(v[15:0]);
      REG_WINDOW: begin
        m_window = v[12:0];
        clear_shadow();
      end
      default: ;
    endcase
  endfunction

  function automatic longint unsigned log2_fixed(longint unsigned x);
    int p;
    longint unsigned m;
    longint unsigned fr;
    p = 63;
    fr = 0;
    while (p > 0 && x[p] == 1'b0) p--;
    m = (p >= 30) ? (x >> (p - 30)) : (x << (30 - p));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      fr = fr << 1;
      if (m >= (64'd2 << 30)) begin
        fr = fr | 1;
        m = m >> 1;
      end
    end
    return (longint'(p) << 16) | fr;
  endfunction

  function automatic int signed window_level(longint unsigned sum, int unsigned w);
    longint signed d, lv;
    if (sum == 0) return -25600;
    d = longint'(log2_fixed(sum)) - longint'(log2_fixed(w)) - 30 * 65536;
    if (d >= 0) return 0;
    lv = -longint'(((unsigned'(-d)) * 197283 + (64'd1 << 23)) >> 24);
    if (lv < -25600) lv = -25600;
    return int'(lv);
  endfunction

  function automatic longint unsigned gained_magnitude(longint unsigned a, int signed g);
    longint signed t, e, n, sh;
    longint unsigned u2, m, q;
    int unsigned f;
    t = longint'(g) * 43541 + 32768;
    e = t >>> 16;
    u2 = unsigned'(e + (64'sd1 << 20));
    n = longint'(u2 >> 10) - 1024;
    f = 32'(u2 & 1023);
    m = 64'd1 << 30;
    for (int k = 0; k < 10; k++)
      if ((f >> (9 - k)) & 1) m = (m * Exp2Tab[k] + (64'd1 << 29)) >> 30;
    sh = 30 - n;
    if (sh < 1) sh = 1;
    if (sh > 62) sh = 62;
    q = (a * m + (64'd1 << (sh - 1))) >> sh;
    return (q > OutLimit) ? OutLimit : q;
  endfunction

  function automatic agc_result_t predict_agc(logic signed [15:0] s);
    agc_result_t r;
    longint unsigned a, sq, old, mag, stp;
    int unsigned w, coef, amag;
    int signed lv, tg, delta, y;
    bit gate;
    a = (s < 0) ? longint'(-int'(s)) : longint'(s);
    sq = a * a;
    if (sq > 64'd1073741823) sq = 64'd1073741823;
    w = (m_window == 0) ? 1 : (m_window > MaxWindow ? MaxWindow : m_window);
    if (m_ptr >= MaxWindow) m_ptr = 0;
    old = m_ring[m_ptr];
    m_ring[m_ptr] = sq;
    m_sum = (m_sum + sq >= old) ? m_sum + sq - old : 0;
    m_ptr = (m_ptr + 1) % w;
    lv = window_level(m_sum, w);
    gate = 1'b0;
    if (lv < m_noise) begin
      gate = 1'b1;
    end else begin
      tg = m_target - lv;
      if (tg > m_maxg) tg = m_maxg;
      if (tg < m_ming) tg = m_ming;
      coef = (tg > m_gain) ? m_attack : m_release;
      delta = tg - m_gain;
      amag = (delta < 0) ? -delta : delta;
      stp = (64'(amag) * (65536 - coef) + 65535) >> 16;
      if (delta < 0) m_gain -= int'(stp);
      else m_gain += int'(stp);
    end
    mag = gained_magnitude(a, m_gain);
    y = (s < 0) ? -int'(mag) : int'(mag);
    r.sample_out = y[15:0];
    r.level_db = lv[15:0];
    r.gain_db = m_gain[14:0];
    r.gate_closed = gate;
    return r;
  endfunction

  // The block drops ready right after a transaction, so acceptance is seen here.
  always @(posedge clk_i) in_taken = rst_ni && in_ch.valid && in_ch.ready;

  // Driver: offers queued samples, with random gaps.
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.sample_in <= '0;
    end else begin
      if (in_taken) begin
        expected_results.push_back(predict_agc(in_ch.sample_in));
        void'(pending_samples.pop_front());
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (!(in_ch.valid && !in_taken) && !stall_free
                   && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(1, 15) - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.sample_in <= pending_samples[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, including one long hold-off.
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!stall_free && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 15) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    agc_result_t got, want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.sample_out = out_ch.sample_out;
      got.level_db = out_ch.level_db;
      got.gain_db = out_ch.gain_db;
      got.gate_closed = out_ch.gate_closed;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  task automatic write_register(reg_idx_e idx, logic [31:0] v);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PaddrW'(int'(idx) * 4);
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    apply_register(idx, v);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] random_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return $signed(16'($urandom_range(0, 255))) - 16'sd128;
      3: return $signed(16'($urandom_range(0, 4095))) - 16'sd2048;
      default: return $signed(16'($urandom));
    endcase
  endfunction

  task automatic random_settings(bit extreme);
    write_register(REG_TARGET, extreme ? 32'h4400 : 32'($urandom_range(0, 15360) * -1));
    write_register(REG_ATTACK, extreme ? 32'd0 : $urandom_range(0, 65535));
    write_register(REG_RELEASE, extreme ? 32'd65535 : $urandom_range(0, 65535));
    write_register(REG_MAXG, extreme ? 32'd0 : $urandom_range(0, 7680));
    write_register(REG_MING, extreme ? 32'd512 : 32'(-$urandom_range(0, 10240)));
    write_register(REG_NOISE, extreme ? 32'(-20480) : 32'(-$urandom_range(7680, 20480)));
    write_register(REG_WINDOW, extreme ? 32'd0 : $urandom_range(1, 64));
    repeat (4400) @(posedge clk_i);
  endtask

  initial begin
    m_target = 0; m_attack = 65535; m_release = 65535; m_maxg = 7680;
    m_ming = -10240; m_noise = -15360; m_window = 4096;
    clear_shadow();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (4400) @(posedge clk_i);

    // Directed: extremes of the sample, big window, then window out of range.
    pending_samples.push_back(16'sh8000);
    pending_samples.push_back(16'sh7fff);
    pending_samples.push_back(16'sh0000);
    pending_samples.push_back(16'sh0001);
    pending_samples.push_back(16'shffff);
    pending_samples.push_back(16'sh5555);
    pending_samples.push_back(16'shaaaa);
    wait_drained();
    write_register(REG_WINDOW, 32'd8191);
    write_register(REG_MING, 32'd7000);
    write_register(REG_MAXG, 32'd100);
    write_register(REG_NOISE, 32'(-7680));
    repeat (4400) @(posedge clk_i);
    for (int i = 0; i < 8; i++) pending_samples.push_back(random_sample());
    wait_drained();
    write_register(REG_NONE, 32'hffff_ffff);
    random_settings(1'b1);
    for (int i = 0; i < 8; i++) pending_samples.push_back(random_sample());
    wait_drained();

    // Random phases; one phase holds the receiver off for a long stretch.
    for (int ph = 0; ph < 6; ph++) begin
      random_settings(1'b0);
      if (ph == 5) stall_free = 1'b1;
      for (int i = 0; i < 155; i++) pending_samples.push_back(random_sample());
      if (ph == 2) begin
        hold_off = 1'b1;
        while (hold_cycles < 600) @(posedge clk_i);
        hold_off = 1'b0;
      end
      wait_drained();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
